FILE: rtl/meter_frame_checker_macros.svh
// Assertion macros shared by the checking logic of the frame checker.
`ifndef METER_FRAME_CHECKER_MACROS_SVH
`define METER_FRAME_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/mfc_pkg.sv
`timescale 1ns / 1ps

package mfc_pkg;

    localparam int MAX_FRAME_BYTES_DEFAULT = 255;
    localparam int MIN_FRAME_BYTES = 11;
    localparam int ADDR_BYTES = 7;
    localparam int ADDR_W = 8 * ADDR_BYTES;
    localparam int ADDR_FIRST_INDEX = 2;
    localparam int ADDR_LAST_INDEX = ADDR_FIRST_INDEX + ADDR_BYTES - 1;

    localparam logic [7:0] HEAD_BYTE = 8'h68;
    localparam logic [7:0] TYPE_BYTE = 8'h10;
    localparam logic [7:0] END_BYTE = 8'h16;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_FRAME    = 3'd1,
        VERDICT_ADDRESS  = 3'd2,
        VERDICT_CHECKSUM = 3'd3,
        VERDICT_SHORT    = 3'd4
    } verdict_t;

    typedef struct packed {
        verdict_t verdict;
        logic     frame_ok;
    } result_t;

endpackage

FILE: rtl/mfc_frame_state.sv
`timescale 1ns / 1ps

module mfc_frame_state #(
    parameter int MAX_FRAME_BYTES = mfc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,
    input  logic [mfc_pkg::ADDR_W-1:0] meter_address,
    output mfc_pkg::result_t          result
);

    localparam int CountW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int AddrIdxW = $clog2(mfc_pkg::ADDR_BYTES);

    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        prev_reg, prev_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              header_fault_reg, header_fault_next;
    logic              address_fault_reg, address_fault_next;

    logic [mfc_pkg::ADDR_BYTES-1:0][7:0] addr_bytes;
    logic [CountW-1:0]   addr_off;
    logic [AddrIdxW-1:0] addr_idx;
    logic                in_addr;
    logic                header_fault_now;
    logic                address_fault_now;
    mfc_pkg::verdict_t   verdict;

    assign addr_bytes = meter_address;
    assign addr_off   = count_reg - CountW'(mfc_pkg::ADDR_FIRST_INDEX);
    assign addr_idx   = addr_off[AddrIdxW-1:0];
    assign in_addr    = (count_reg >= CountW'(mfc_pkg::ADDR_FIRST_INDEX))
                     && (count_reg <= CountW'(mfc_pkg::ADDR_LAST_INDEX));

    always_comb
    begin
        header_fault_now = header_fault_reg
            || ((count_reg == CountW'(0)) && (data_byte != mfc_pkg::HEAD_BYTE))
            || ((count_reg == CountW'(1)) && (data_byte != mfc_pkg::TYPE_BYTE));
        address_fault_now = address_fault_reg
            || (in_addr && (data_byte != addr_bytes[addr_idx]));

        // The last byte brings the total to count plus one.
        if (count_reg < CountW'(mfc_pkg::MIN_FRAME_BYTES - 1))
            verdict = mfc_pkg::VERDICT_SHORT;
        else if (header_fault_now || (data_byte != mfc_pkg::END_BYTE))
            verdict = mfc_pkg::VERDICT_FRAME;
        else if (address_fault_now)
            verdict = mfc_pkg::VERDICT_ADDRESS;
        else if (prev_reg != sum_reg)
            verdict = mfc_pkg::VERDICT_CHECKSUM;
        else
            verdict = mfc_pkg::VERDICT_OK;

        result.verdict  = verdict;
        result.frame_ok = (verdict == mfc_pkg::VERDICT_OK);
    end

    always_comb
    begin
        sum_next           = sum_reg;
        prev_next          = prev_reg;
        count_next         = count_reg;
        header_fault_next  = header_fault_reg;
        address_fault_next = address_fault_reg;
        if (step)
        begin
            if (last_byte)
            begin
                sum_next           = '0;
                prev_next          = '0;
                count_next         = '0;
                header_fault_next  = 1'b0;
                address_fault_next = 1'b0;
            end
            else
            begin
                // The byte held back may be the checksum, so it joins the sum one byte late.
                if (count_reg != CountW'(0))
                    sum_next = sum_reg + prev_reg;
                prev_next = data_byte;
                if (count_reg < CountW'(MAX_FRAME_BYTES))
                    count_next = count_reg + CountW'(1);
                header_fault_next  = header_fault_now;
                address_fault_next = address_fault_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg           <= '0;
            prev_reg          <= '0;
            count_reg         <= '0;
            header_fault_reg  <= 1'b0;
            address_fault_reg <= 1'b0;
        end
        else
        begin
            sum_reg           <= sum_next;
            prev_reg          <= prev_next;
            count_reg         <= count_next;
            header_fault_reg  <= header_fault_next;
            address_fault_reg <= address_fault_next;
        end
    end

endmodule

FILE: rtl/meter_frame_checker.sv
`timescale 1ns / 1ps
// Result path: the last byte of a frame passes the input register, then the result register once it has room.
// Throughput: one byte per cycle; the input register and the result register stall only
// while a finished verdict waits to be taken.
// Reset: asynchronous and active low; it clears the frame state, the meter address
// and both valid flags.

`include "meter_frame_checker_macros.svh"

module meter_frame_checker #(
    parameter int MAX_FRAME_BYTES = mfc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mfc_pkg::ADDR_W-1:0] meter_address,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 verdict,
    output logic                       frame_ok
);

    logic [mfc_pkg::ADDR_W-1:0] addr_reg;
    logic                       s1_valid_reg, s1_valid_next;
    logic [7:0]                 s1_data_reg;
    logic                       s1_last_reg;
    logic                       out_valid_reg, out_valid_next;
    mfc_pkg::result_t           result_reg;
    mfc_pkg::result_t           result;
    logic                       step;
    logic                       in_accept;

    assign cfg_ready = 1'b1;

    // A non-final byte never blocks; a final one waits for room in the result register.
    assign step      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || step;
    assign in_accept = in_valid && in_ready;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !step);
    assign out_valid_next = (step && s1_last_reg) || (out_valid_reg && !out_ready);

    mfc_frame_state #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (s1_data_reg),
        .last_byte    (s1_last_reg),
        .meter_address(addr_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                addr_reg <= meter_address;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (step && s1_last_reg)
            result_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = result_reg.verdict;
    assign frame_ok  = result_reg.frame_ok;

    `MFC_ASSERT_NEXT(a_verdict_loaded, step && s1_last_reg, out_valid_reg)
    `MFC_ASSERT_NOW(a_no_overwrite, out_valid_reg && !out_ready, !(step && s1_last_reg))
    `MFC_ASSERT_NEXT(a_item_held, in_accept, s1_valid_reg)
    `MFC_ASSERT_NOW(a_ok_matches, out_valid_reg,
        result_reg.frame_ok == (result_reg.verdict == mfc_pkg::VERDICT_OK))

endmodule
